// ===== hdl/hfd_pkg.sv =====
`default_nettype none

package hfd_pkg;

  // Field widths of the received stream and the decoded result.
  localparam int unsigned RxByteW    = 8;
  localparam int unsigned RawW       = 16;
  localparam int unsigned TempGainW  = 15;
  localparam int unsigned TempOffW   = 16;
  localparam int unsigned HumGainW   = 15;
  localparam int unsigned TempW      = 19;
  localparam int unsigned HumW       = 18;
  localparam int unsigned ScaleShift = 13;
  localparam int unsigned ProdW      = TempGainW + RawW;
  localparam int unsigned OutDataW   = ((TempW + HumW + 7) / 8) * 8;
  localparam int unsigned OutUserW   = 3;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Frame queue between the byte parser and the scaling datapath.
  localparam int unsigned QueueDepth = 4;

  // CRC-8, polynomial x^8 + x^5 + x^4 + 1, no reflection, no final xor.
  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [7:0] CrcInit = 8'hFF;

  // Register reset values.
  localparam logic [TempGainW-1:0] TempGainReset = 15'd21875;
  localparam logic [TempOffW-1:0]  TempOffReset  = 16'd45000;
  localparam logic [HumGainW-1:0]  HumGainReset  = 15'd12500;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TEMP_FAIL = 2'd1,
    STATUS_HUM_FAIL  = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TEMP_GAIN   = 2'd0,
    CFG_TEMP_OFFSET = 2'd1,
    CFG_HUM_GAIN    = 2'd2
  } cfg_idx_e;

  // One complete frame as handed from the parser to the datapath.
  typedef struct packed {
    logic [RawW-1:0] temp_code;
    logic [RawW-1:0] hum_code;
    status_e         status;
  } frame_job_t;

  typedef struct packed {
    logic [TempGainW-1:0] temp_gain;
    logic [TempOffW-1:0]  temp_offset;
    logic [HumGainW-1:0]  hum_gain;
  } scale_cfg_t;

  // One byte of the CRC-8 update, MSB first.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/humidity_temp_frame_decoder_core.sv =====
// Decoder for the six-byte measurement response of a humidity and temperature
// sensor. Bytes arrive one word at a time on the s_axis channel; tuser marks
// the first byte of a response and resynchronises the byte position, dropping
// any partial frame. Each two-byte reading is followed by a CRC-8 check byte
// (polynomial 0x31, start value 0xFF), temperature first.
// On the sixth byte one word leaves on m_axis: the stored temperature in
// milli-degrees and humidity in milli-percent, a status code and a flag that
// says whether any frame has passed both checks since reset. A failed frame
// carries the previous good values; if both checks fail, the temperature
// failure is reported.
// The block takes one byte per cycle while the frame queue is not full. Each
// finished frame passes the queue, the product register and the result register
// before its word appears. A small frame queue separates the byte parser from
// the scaling datapath, so bytes keep flowing while m_axis is stalled until
// the queue is full; only then does s_axis_tready fall.
// Reset clears the byte position, the stored reading and the queue, and loads
// the scale registers with their defaults. The cfg port always accepts a word;
// write it only while no frame is in flight.

`default_nettype none

module humidity_temp_frame_decoder_core #(
  parameter int unsigned QueueDepth = hfd_pkg::QueueDepth
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Received bytes.
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [hfd_pkg::RxByteW-1:0]     s_axis_tdata,  // [7:0] rx_byte
  input  wire logic                            s_axis_tuser,  // [0] frame_start
  // Decoded readings.
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [18:0] temp_milli_c, [36:19] humidity_milli_pct, [39:37] zero
  output logic [hfd_pkg::OutDataW-1:0]         m_axis_tdata,
  // [1:0] status, [2] has_reading
  output logic [hfd_pkg::OutUserW-1:0]         m_axis_tuser,
  // Register writes.
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [hfd_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [hfd_pkg::CfgDataW-1:0]    cfg_data_i
);

  localparam int unsigned PadW = hfd_pkg::OutDataW - hfd_pkg::TempW - hfd_pkg::HumW;

  hfd_pkg::scale_cfg_t          cfg_q;
  hfd_pkg::frame_job_t          push_job, pop_job;
  logic                         push, full, pop_valid, pop;
  logic [hfd_pkg::TempW-1:0]    out_temp;
  logic [hfd_pkg::HumW-1:0]     out_hum;
  hfd_pkg::status_e             out_status;
  logic                         out_has_reading;
  logic [PadW-1:0]              pad;

  // Scale registers. Writes to an index beyond the list are ignored.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.temp_gain   <= hfd_pkg::TempGainReset;
      cfg_q.temp_offset <= hfd_pkg::TempOffReset;
      cfg_q.hum_gain    <= hfd_pkg::HumGainReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        hfd_pkg::CFG_TEMP_GAIN: begin
          cfg_q.temp_gain <= cfg_data_i[hfd_pkg::TempGainW-1:0];
        end
        hfd_pkg::CFG_TEMP_OFFSET: begin
          cfg_q.temp_offset <= cfg_data_i[hfd_pkg::TempOffW-1:0];
        end
        hfd_pkg::CFG_HUM_GAIN: begin
          cfg_q.hum_gain <= cfg_data_i[hfd_pkg::HumGainW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Byte parser: position tracking, word assembly and both CRC checks.
  hfd_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .in_byte_i        (s_axis_tdata),
    .in_frame_start_i (s_axis_tuser),
    .push_o           (push),
    .job_o            (push_job),
    .full_i           (full)
  );

  // Frame queue between parser and datapath.
  hfd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_job_i  (push_job),
    .full_o      (full),
    .pop_valid_o (pop_valid),
    .pop_job_o   (pop_job),
    .pop_i       (pop)
  );

  // Scaling datapath and result register.
  hfd_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .job_valid_i       (pop_valid),
    .job_i             (pop_job),
    .pop_o             (pop),
    .cfg_i             (cfg_q),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .out_temp_o        (out_temp),
    .out_hum_o         (out_hum),
    .out_status_o      (out_status),
    .out_has_reading_o (out_has_reading)
  );

  assign pad          = '0;
  assign m_axis_tdata = {pad, out_hum, out_temp};
  assign m_axis_tuser = {out_has_reading, out_status};

endmodule

`default_nettype wire

// ===== hdl/hfd_front.sv =====
`default_nettype none

module hfd_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [hfd_pkg::RxByteW-1:0]  in_byte_i,
  input  wire logic                         in_frame_start_i,
  output logic                              push_o,
  output hfd_pkg::frame_job_t               job_o,
  input  wire logic                         full_i
);

  typedef enum logic [5:0] {
    POS_TEMP_HI  = 6'b000001,
    POS_TEMP_LO  = 6'b000010,
    POS_TEMP_CRC = 6'b000100,
    POS_HUM_HI   = 6'b001000,
    POS_HUM_LO   = 6'b010000,
    POS_HUM_CRC  = 6'b100000
  } byte_pos_e;

  byte_pos_e                   pos_q, pos_d, cur_pos;
  logic [7:0]                  crc_q, crc_d;
  logic                        temp_ok_q, temp_ok_d;
  logic [hfd_pkg::RawW-1:0]    temp_word_q, temp_word_d;
  logic [hfd_pkg::RawW-1:0]    hum_word_q, hum_word_d;
  logic                        accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign cur_pos    = in_frame_start_i ? POS_TEMP_HI : pos_q;

  always_comb begin
    pos_d           = pos_q;
    crc_d           = crc_q;
    temp_ok_d       = temp_ok_q;
    temp_word_d     = temp_word_q;
    hum_word_d      = hum_word_q;
    push_o          = 1'b0;
    job_o.temp_code = temp_word_q;
    job_o.hum_code  = hum_word_q;
    job_o.status    = hfd_pkg::STATUS_OK;
    if (!temp_ok_q) begin
      job_o.status = hfd_pkg::STATUS_TEMP_FAIL;
    end else if (crc_q != in_byte_i) begin
      job_o.status = hfd_pkg::STATUS_HUM_FAIL;
    end
    if (accept) begin
      unique case (cur_pos)
        POS_TEMP_HI: begin
          temp_word_d = {in_byte_i, temp_word_q[7:0]};
          crc_d       = hfd_pkg::crc8_update(hfd_pkg::CrcInit, in_byte_i);
          pos_d       = POS_TEMP_LO;
        end
        POS_TEMP_LO: begin
          temp_word_d = {temp_word_q[15:8], in_byte_i};
          crc_d       = hfd_pkg::crc8_update(crc_q, in_byte_i);
          pos_d       = POS_TEMP_CRC;
        end
        POS_TEMP_CRC: begin
          temp_ok_d = (crc_q == in_byte_i);
          crc_d     = hfd_pkg::CrcInit;
          pos_d     = POS_HUM_HI;
        end
        POS_HUM_HI: begin
          hum_word_d = {in_byte_i, hum_word_q[7:0]};
          crc_d      = hfd_pkg::crc8_update(hfd_pkg::CrcInit, in_byte_i);
          pos_d      = POS_HUM_LO;
        end
        POS_HUM_LO: begin
          hum_word_d = {hum_word_q[15:8], in_byte_i};
          crc_d      = hfd_pkg::crc8_update(crc_q, in_byte_i);
          pos_d      = POS_HUM_CRC;
        end
        POS_HUM_CRC: begin
          push_o    = 1'b1;
          crc_d     = hfd_pkg::CrcInit;
          temp_ok_d = 1'b0;
          pos_d     = POS_TEMP_HI;
        end
        default: begin
          pos_d = POS_TEMP_HI;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= POS_TEMP_HI;
      crc_q     <= hfd_pkg::CrcInit;
      temp_ok_q <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      crc_q     <= crc_d;
      temp_ok_q <= temp_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    temp_word_q <= temp_word_d;
    hum_word_q  <= hum_word_d;
  end

endmodule

`default_nettype wire

// ===== hdl/hfd_queue.sv =====
`default_nettype none

module hfd_queue #(
  parameter int unsigned Depth = hfd_pkg::QueueDepth
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire hfd_pkg::frame_job_t push_job_i,
  output logic              full_o,
  output logic              pop_valid_o,
  output hfd_pkg::frame_job_t pop_job_o,
  input  wire logic         pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  hfd_pkg::frame_job_t mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                do_push, do_pop;

  assign full_o      = (count_q == CntW'(Depth));
  assign pop_valid_o = (count_q != '0);
  assign pop_job_o   = mem_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hfd_back.sv =====
`default_nettype none

module hfd_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       job_valid_i,
  input  wire hfd_pkg::frame_job_t        job_i,
  output logic                            pop_o,
  input  wire hfd_pkg::scale_cfg_t        cfg_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [hfd_pkg::TempW-1:0]       out_temp_o,
  output logic [hfd_pkg::HumW-1:0]        out_hum_o,
  output hfd_pkg::status_e                out_status_o,
  output logic                            out_has_reading_o
);

  // Stage one: both products.
  logic                         s1_valid_q, s1_valid_d;
  hfd_pkg::status_e             s1_status_q;
  logic [hfd_pkg::ProdW-1:0]    s1_tprod_q, s1_hprod_q;

  // Stage two: result slot, which also holds the last good reading.
  logic                         out_valid_q, out_valid_d;
  hfd_pkg::status_e             out_status_q;
  logic [hfd_pkg::TempW-1:0]    last_temp_q;
  logic [hfd_pkg::HumW-1:0]     last_hum_q;
  logic                         has_reading_q;

  logic                         out_adv, s1_take, s2_load;
  logic [hfd_pkg::HumW-1:0]     t_scaled;
  logic [hfd_pkg::TempW-1:0]    t_milli;

  assign out_adv    = !out_valid_q || out_ready_i;
  assign s1_take    = !s1_valid_q || out_adv;
  assign pop_o      = job_valid_i && s1_take;
  assign s2_load    = s1_valid_q && out_adv;
  assign s1_valid_d = s1_take ? job_valid_i : s1_valid_q;
  assign out_valid_d = out_adv ? s1_valid_q : out_valid_q;

  assign t_scaled = s1_tprod_q[hfd_pkg::ProdW-1:hfd_pkg::ScaleShift];
  // Wraps in two's complement, so a reading below the offset comes out negative.
  assign t_milli  = hfd_pkg::TempW'(t_scaled) - hfd_pkg::TempW'(cfg_i.temp_offset);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      last_temp_q   <= '0;
      last_hum_q    <= '0;
      has_reading_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s2_load && (s1_status_q == hfd_pkg::STATUS_OK)) begin
        last_temp_q   <= t_milli;
        last_hum_q    <= s1_hprod_q[hfd_pkg::ProdW-1:hfd_pkg::ScaleShift];
        has_reading_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_status_q <= job_i.status;
      s1_tprod_q  <= hfd_pkg::ProdW'(cfg_i.temp_gain) * hfd_pkg::ProdW'(job_i.temp_code);
      s1_hprod_q  <= hfd_pkg::ProdW'(cfg_i.hum_gain) * hfd_pkg::ProdW'(job_i.hum_code);
    end
    if (s2_load) begin
      out_status_q <= s1_status_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_temp_o        = last_temp_q;
  assign out_hum_o         = last_hum_q;
  assign out_status_o      = out_status_q;
  assign out_has_reading_o = has_reading_q;

endmodule

`default_nettype wire
